### sv/mta_pkg.sv
package mta_pkg;

    localparam int IDX_W            = 10;
    localparam int COORD_W          = 32;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int PROD_W           = 2 * DIFF_W;
    localparam int WIDE_W           = PROD_W + 1;
    localparam int NORM_W           = WIDE_W;
    localparam int SUM_W            = 42;
    localparam int UNIT_W           = 32;
    localparam int UNIT_BITS        = 30;
    localparam int VTX_W            = 5 * COORD_W;
    localparam int SUMS_W           = 3 * SUM_W;
    localparam int VERTEX_DEPTH_DEF = 1024;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_TRI  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DEGEN = 2'd1;
    localparam logic [1:0] STAT_ZERO  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_CAPT,
        S_MUL,
        S_NSTART,
        S_NWAIT,
        S_SUMRD,
        S_SUMWR,
        S_RDSUM,
        S_RDCAP,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DLOAD,
        N_DIV,
        N_DONE
    } t_nstate;

    typedef struct packed {
        logic       start;
        logic [2:0] neg;
    } t_norm_req;

    typedef struct packed {
        logic done;
        logic zero;
    } t_norm_rsp;

endpackage

### sv/mta_ram.sv
module mta_ram import mta_pkg::*; #(
    parameter int WIDTH = VTX_W,
    parameter int DEPTH = VERTEX_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/mta_norm.sv
module mta_norm import mta_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_norm_req                i_req,
    input  logic [NORM_W-1:0]        i_mag [3],
    output t_norm_rsp                o_rsp,
    output logic signed [UNIT_W-1:0] o_unit [3]
);

    t_nstate r_state, n_state;

    logic [NORM_W-1:0]        r_m [3];
    logic [2:0]               r_neg;
    logic [59:0]              r_prod;
    logic [61:0]              r_sq;
    logic [4:0]               r_cnt;
    logic [1:0]               r_comp;
    logic [61:0]              r_x;
    logic [62:0]              r_root;
    logic [62:0]              r_bit;
    logic [30:0]              r_rem;
    logic [30:0]              r_low;
    logic [30:0]              r_q;
    logic signed [UNIT_W-1:0] r_unit [3];
    logic                     r_zero;

    logic [NORM_W-1:0] or_all;
    logic              all_zero, hi8, hi1, lo8, shift_done;
    logic [29:0]       c_sel;
    logic [59:0]       sq_p;
    logic [61:0]       sq_sum;
    logic [62:0]       rt_trial;
    logic              rt_take;
    logic [30:0]       n_root;
    logic [60:0]       num;
    logic [31:0]       dv_trial;
    logic              dv_take;
    logic [30:0]       q_next;

    assign or_all     = r_m[0] | r_m[1] | r_m[2];
    assign all_zero   = ~|(i_mag[0] | i_mag[1] | i_mag[2]);
    assign hi8        = |or_all[NORM_W-1:UNIT_BITS+8];
    assign hi1        = |or_all[NORM_W-1:UNIT_BITS];
    assign lo8        = ~|or_all[UNIT_BITS-1:UNIT_BITS-8];
    assign shift_done = !hi1 && or_all[UNIT_BITS-1];

    assign c_sel  = r_m[r_cnt[1:0]][UNIT_BITS-1:0];
    assign sq_p   = c_sel * c_sel;
    assign sq_sum = r_sq + 62'(r_prod);

    assign rt_trial = r_root + r_bit;
    assign rt_take  = {1'b0, r_x} >= rt_trial;
    assign n_root   = r_root[30:0];

    assign num      = {1'b0, r_m[r_comp][UNIT_BITS-1:0], 30'b0} + 61'(n_root[30:1]);
    assign dv_trial = {r_rem, r_low[30]};
    assign dv_take  = dv_trial >= {1'b0, n_root};
    assign q_next   = {r_q[29:0], dv_take};

    always_comb begin
        n_state = r_state;
        case (r_state)
            N_IDLE:  if (i_req.start) n_state = all_zero ? N_DONE : N_SHIFT;
            N_SHIFT: if (shift_done) n_state = N_SQ;
            N_SQ:    if (r_cnt == 5'd3) n_state = N_SQRT;
            N_SQRT:  if (r_cnt == 5'd31) n_state = N_DLOAD;
            N_DLOAD: n_state = N_DIV;
            N_DIV: begin
                if (r_cnt == 5'd0) n_state = (r_comp == 2'd2) ? N_DONE : N_DLOAD;
            end
            N_DONE:  n_state = N_IDLE;
            default: n_state = N_IDLE;
        endcase
    end

    always_comb begin
        o_rsp.done = (r_state == N_DONE);
        o_rsp.zero = r_zero;
        o_unit     = r_unit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            N_IDLE: begin
                r_m    <= i_mag;
                r_neg  <= i_req.neg;
                r_zero <= all_zero;
                r_sq   <= '0;
                r_cnt  <= '0;
                r_comp <= '0;
            end
            N_SHIFT: begin
                // truncate toward zero on the way down, exact on the way up
                for (int i = 0; i < 3; i++) begin
                    if (hi8) begin
                        r_m[i] <= r_m[i] >> 8;
                    end else if (hi1) begin
                        r_m[i] <= r_m[i] >> 1;
                    end else if (lo8) begin
                        r_m[i] <= r_m[i] << 8;
                    end else if (!or_all[UNIT_BITS-1]) begin
                        r_m[i] <= r_m[i] << 1;
                    end
                end
            end
            N_SQ: begin
                r_prod <= sq_p;
                if (r_cnt != 5'd0) begin
                    r_sq <= sq_sum;
                end
                if (r_cnt == 5'd3) begin
                    r_x    <= sq_sum;
                    r_root <= '0;
                    r_bit  <= 63'd1 << 62;
                    r_cnt  <= '0;
                end else begin
                    r_cnt <= r_cnt + 5'd1;
                end
            end
            N_SQRT: begin
                if (rt_take) begin
                    r_x    <= r_x - rt_trial[61:0];
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 5'd1;
            end
            N_DLOAD: begin
                r_rem <= {1'b0, num[60:31]};
                r_low <= num[30:0];
                r_q   <= '0;
                r_cnt <= 5'd30;
            end
            N_DIV: begin
                r_rem <= dv_take ? 31'(dv_trial - {1'b0, n_root}) : dv_trial[30:0];
                r_low <= r_low << 1;
                r_q   <= q_next;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_unit[r_comp] <= r_neg[r_comp] ? -UNIT_W'(q_next) : UNIT_W'(q_next);
                    r_comp         <= r_comp + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/mesh_tangent_accumulator_core.sv
// Per-vertex tangent accumulator (Lengyel's method), fixed point.
// Command channel: raise start with i_cmd and its fields; the item is taken at
// the clock edge where start is high and busy is low. busy stays high until
// the result has been shown. Each item yields exactly one result, shown for a
// single cycle with o_done high; the receiver cannot stall, so the result must
// be captured in that cycle.
//   load (cmd 0), unused code, index out of range: o_done in the cycle after acceptance.
//   read (cmd 2): sum memory read, then normalize; an all-zero sum skips the normalize steps.
//   triangle (cmd 1): a zero determinant ends right after the multiply step.
// The normalize unit runs a shift search, a sum of squares, a square root and
// the three component divides (a load state and 31 quotient bits each). A
// triangle adds the corner fetch through the vertex memory read port, the shared
// 33x33 multiplier and the read-modify-write of three tangent sums through the
// sum memory port.
// Only one item is in flight at a time; the next item can be taken in the
// cycle after o_done.
// Reset (synchronous, active low) returns the control to idle; both memories
// hold no reset and an entry must be loaded before a triangle or read uses it.
module mesh_tangent_accumulator_core import mta_pkg::*; #(
    parameter int VERTEX_DEPTH = VERTEX_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_cmd,
    input  logic [IDX_W-1:0]         i_vertex_index,
    input  logic [IDX_W-1:0]         i_corner_b,
    input  logic [IDX_W-1:0]         i_corner_c,
    input  logic signed [COORD_W-1:0] i_pos_x,
    input  logic signed [COORD_W-1:0] i_pos_y,
    input  logic signed [COORD_W-1:0] i_pos_z,
    input  logic signed [COORD_W-1:0] i_tex_u,
    input  logic signed [COORD_W-1:0] i_tex_v,
    output logic                     o_done,
    output logic signed [UNIT_W-1:0] o_tangent_x,
    output logic signed [UNIT_W-1:0] o_tangent_y,
    output logic signed [UNIT_W-1:0] o_tangent_z,
    output logic [1:0]               o_status
);

    localparam int AW = $clog2(VERTEX_DEPTH);

    t_state r_state, n_state;

    logic [1:0]               r_cmd;
    logic [IDX_W-1:0]         r_idx [3];
    logic [1:0]               r_k;
    logic signed [COORD_W-1:0] r_pa [5];   // x, y, z, u, v of corner a
    logic signed [DIFF_W-1:0] r_d1 [5];    // e1 x/y/z, du1, dv1
    logic signed [DIFF_W-1:0] r_d2 [5];    // e2 x/y/z, du2, dv2
    logic [3:0]               r_step;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [WIDE_W-1:0] r_det;
    logic signed [WIDE_W-1:0] r_v [3];
    logic                     r_flip;
    logic signed [UNIT_W-1:0] r_t [3];
    logic signed [UNIT_W-1:0] r_out [3];
    logic [1:0]               r_status;

    logic                     accept, in_a, in_b, in_c;
    logic                     vtx_we, sum_we;
    logic [AW-1:0]            vtx_waddr, sum_waddr, raddr;
    logic [VTX_W-1:0]         vtx_wdata, vtx_rdata;
    logic [SUMS_W-1:0]        sum_wdata, sum_rdata;
    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [WIDE_W-1:0] mul_diff;
    logic signed [DIFF_W-1:0] fetch_d [5];
    logic                     degen;
    t_norm_req                norm_req;
    t_norm_rsp                norm_rsp;
    logic [NORM_W-1:0]        norm_mag [3];
    logic [2:0]               norm_neg;
    logic signed [UNIT_W-1:0] norm_unit [3];
    logic signed [SUM_W:0]    sat_raw [3];
    logic signed [SUM_W-1:0]  sat_sum [3];

    assign accept = start && !busy;
    assign in_a   = 32'(i_vertex_index) < 32'(VERTEX_DEPTH);
    assign in_b   = 32'(i_corner_b) < 32'(VERTEX_DEPTH);
    assign in_c   = 32'(i_corner_c) < 32'(VERTEX_DEPTH);
    assign degen  = (r_cmd == CMD_TRI) && (r_det == '0);
    assign raddr  = AW'(r_idx[r_k]);

    // vertex word: x, y, z, u, v from the top down
    mta_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (vtx_waddr),
        .i_wdata (vtx_wdata),
        .i_raddr (raddr),
        .o_rdata (vtx_rdata)
    );

    // sum word: x, y, z from the top down
    mta_ram #(.WIDTH(SUMS_W), .DEPTH(VERTEX_DEPTH)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (raddr),
        .o_rdata (sum_rdata)
    );

    mta_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (norm_req),
        .i_mag   (norm_mag),
        .o_rsp   (norm_rsp),
        .o_unit  (norm_unit)
    );

    // corner minus corner a, one field per lane
    always_comb begin
        for (int j = 0; j < 5; j++) begin
            fetch_d[j] = DIFF_W'($signed(vtx_rdata[COORD_W*(4-j) +: COORD_W]))
                       - DIFF_W'(r_pa[j]);
        end
    end

    // shared multiplier: det first, then the three tangent components
    always_comb begin
        case (r_step)
            4'd0:    begin mul_a = r_d1[3]; mul_b = r_d2[4]; end
            4'd1:    begin mul_a = r_d2[3]; mul_b = r_d1[4]; end
            4'd2:    begin mul_a = r_d2[4]; mul_b = r_d1[0]; end
            4'd3:    begin mul_a = r_d1[4]; mul_b = r_d2[0]; end
            4'd4:    begin mul_a = r_d2[4]; mul_b = r_d1[1]; end
            4'd5:    begin mul_a = r_d1[4]; mul_b = r_d2[1]; end
            4'd6:    begin mul_a = r_d2[4]; mul_b = r_d1[2]; end
            4'd7:    begin mul_a = r_d1[4]; mul_b = r_d2[2]; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign mul_diff = WIDE_W'(r_acc) - WIDE_W'(r_prod);

    // sign-magnitude operands for the normalize unit; flip all by sign of det
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            norm_mag[i] = r_v[i][WIDE_W-1] ? NORM_W'(-r_v[i]) : NORM_W'(r_v[i]);
            norm_neg[i] = r_v[i][WIDE_W-1] ^ r_flip;
        end
    end

    // saturate each sum at the 42-bit signed limits
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sat_raw[i] = (SUM_W+1)'($signed(sum_rdata[SUM_W*(2-i) +: SUM_W]))
                       + (SUM_W+1)'(r_t[i]);
            if (sat_raw[i][SUM_W] != sat_raw[i][SUM_W-1]) begin
                sat_sum[i] = sat_raw[i][SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                               : {1'b0, {(SUM_W-1){1'b1}}};
            end else begin
                sat_sum[i] = sat_raw[i][SUM_W-1:0];
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_cmd)
                        CMD_TRI:  n_state = (in_a && in_b && in_c) ? S_FETCH : S_DONE;
                        CMD_READ: n_state = in_a ? S_RDSUM : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_FETCH:  n_state = S_CAPT;
            S_CAPT:   n_state = (r_k == 2'd2) ? S_MUL : S_FETCH;
            S_MUL:    if (r_step == 4'd8) n_state = S_NSTART;
            S_NSTART: n_state = degen ? S_DONE : S_NWAIT;
            S_NWAIT: begin
                if (norm_rsp.done) begin
                    n_state = (!norm_rsp.zero && r_cmd == CMD_TRI) ? S_SUMRD : S_DONE;
                end
            end
            S_SUMRD:  n_state = S_SUMWR;
            S_SUMWR:  n_state = (r_k == 2'd2) ? S_DONE : S_SUMRD;
            S_RDSUM:  n_state = S_RDCAP;
            S_RDCAP:  n_state = S_NSTART;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        busy           = (r_state != S_IDLE);
        o_done         = (r_state == S_DONE);
        norm_req.start = (r_state == S_NSTART) && !degen;
        norm_req.neg   = norm_neg;
        vtx_we         = (r_state == S_IDLE) && accept && (i_cmd == CMD_LOAD) && in_a;
        vtx_waddr      = AW'(i_vertex_index);
        vtx_wdata      = {i_pos_x, i_pos_y, i_pos_z, i_tex_u, i_tex_v};
        if (r_state == S_SUMWR) begin
            sum_we    = 1'b1;
            sum_waddr = raddr;
            sum_wdata = {sat_sum[0], sat_sum[1], sat_sum[2]};
        end else begin
            sum_we    = vtx_we;
            sum_waddr = AW'(i_vertex_index);
            sum_wdata = '0;
        end
    end

    assign o_tangent_x = r_out[0];
    assign o_tangent_y = r_out[1];
    assign o_tangent_z = r_out[2];
    assign o_status    = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // preset the failure answer; a good outcome overwrites it
                r_cmd    <= i_cmd;
                r_idx[0] <= i_vertex_index;
                r_idx[1] <= i_corner_b;
                r_idx[2] <= i_corner_c;
                r_k      <= '0;
                r_step   <= '0;
                r_flip   <= 1'b0;
                r_out    <= '{default: '0};
                case (i_cmd)
                    CMD_TRI:  r_status <= STAT_DEGEN;
                    CMD_READ: r_status <= STAT_ZERO;
                    default:  r_status <= STAT_OK;
                endcase
            end
            S_CAPT: begin
                case (r_k)
                    2'd0: begin
                        for (int j = 0; j < 5; j++) begin
                            r_pa[j] <= $signed(vtx_rdata[COORD_W*(4-j) +: COORD_W]);
                        end
                    end
                    2'd1:    r_d1 <= fetch_d;
                    default: r_d2 <= fetch_d;
                endcase
                r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            S_MUL: begin
                r_prod <= mul_p;
                r_step <= r_step + 4'd1;
                // consume the registered product of the previous step
                case (r_step)
                    4'd1, 4'd3, 4'd5, 4'd7: r_acc <= r_prod;
                    4'd2: begin
                        r_det  <= mul_diff;
                        r_flip <= mul_diff[WIDE_W-1];
                    end
                    4'd4:    r_v[0] <= mul_diff;
                    4'd6:    r_v[1] <= mul_diff;
                    4'd8:    r_v[2] <= mul_diff;
                    default: begin
                    end
                endcase
            end
            S_NWAIT: begin
                if (norm_rsp.done && !norm_rsp.zero) begin
                    r_t <= norm_unit;
                    if (r_cmd != CMD_TRI) begin
                        r_out    <= norm_unit;
                        r_status <= STAT_OK;
                    end
                end
            end
            S_SUMWR: begin
                r_k <= r_k + 2'd1;
                if (r_k == 2'd2) begin
                    r_out    <= r_t;
                    r_status <= STAT_OK;
                end
            end
            S_RDCAP: begin
                for (int i = 0; i < 3; i++) begin
                    r_v[i] <= WIDE_W'($signed(sum_rdata[SUM_W*(2-i) +: SUM_W]));
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### sv/mta_checker.sv
module mta_checker import mta_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_done,
    input logic signed [UNIT_W-1:0] o_tangent_x,
    input logic signed [UNIT_W-1:0] o_tangent_y,
    input logic signed [UNIT_W-1:0] o_tangent_z,
    input logic [1:0]               o_status
);

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy low after accept");

    // a result is shown while busy and frees the block right after
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy ##1 !busy)
        else $error("result strobe outside an item");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // a failed item reports the zero vector
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status == STAT_DEGEN || o_status == STAT_ZERO)
            |-> o_tangent_x == '0 && o_tangent_y == '0 && o_tangent_z == '0)
        else $error("nonzero tangent with failure status");

endmodule

bind mesh_tangent_accumulator_core mta_checker u_mta_checker (.*);
